### src/mhpq_pkg.sv
// Shared constants for the max heap priority queue: sizes, command and status codes.
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Wide enough to hold a child index of any slot, including the right child of the last one.
  localparam int PTR_W    = ADDR_W + 2;

  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

endpackage

### src/mhpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/max_heap_priority_queue.sv
// Binary max heap priority queue held in one RAM, walked by a sequencer.
//
//  channel | direction | tdata (low bit up)                  | tuser
//  in_     | in        | value[31:0]                         | cmd[1:0]
//  out_    | out       | top_value[31:0], count[38:32], 0    | status[1:0]
//
// One word is taken only while the sequencer is idle, and each costs its walk through the RAM.
// Query and a refused push go straight to DONE; a push moves smaller parents down a level as it
// climbs, then writes the value. Delete scans for the value (not found if absent), moves each
// ancestor of the hit down a level, reads the last entry into the root hole and sifts it down.
// Reset (rst_n low, synchronous) empties the heap; RAM contents are left as they are.
// A result that is not taken holds the output register, and the sequencer then waits in DONE.
module max_heap_priority_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mhpq_pkg::IN_DATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic [mhpq_pkg::CMD_W-1:0]      in_tuser,   // cmd[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mhpq_pkg::OUT_DATA_W-1:0] out_tdata,  // top_value[31:0], count[38:32]
  output logic [mhpq_pkg::ST_W-1:0]       out_tuser   // status[1:0]
);
  import mhpq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_SH_RD   = 4'd4;
  localparam logic [3:0] S_SH_WR   = 4'd5;
  localparam logic [3:0] S_LAST_RD = 4'd6;
  localparam logic [3:0] S_LAST_WR = 4'd7;
  localparam logic [3:0] S_SD_L    = 4'd8;
  localparam logic [3:0] S_SD_R    = 4'd9;
  localparam logic [3:0] S_SD_C    = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]               state_r, state_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] lval_r, lval_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         scan_r, scan_nxt;
  logic                     pend_r, pend_nxt;
  logic [ST_W-1:0]          st_r, st_nxt;
  logic signed [DATA_W-1:0] root_r;

  logic                     out_valid_r;
  logic [ST_W-1:0]          out_st_r;
  logic [DATA_W-1:0]        out_top_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_load;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] rd_val;

  logic [ADDR_W-1:0]        parent;
  logic [PTR_W-1:0]         lchild;
  logic [PTR_W-1:0]         rchild;
  logic [PTR_W-1:0]         cnt_ext;
  logic [CNT_W-1:0]         scan_prev;
  logic signed [DATA_W-1:0] cand;
  logic [ADDR_W-1:0]        cand_idx;
  logic                     cand_move;

  mhpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_val    = $signed(rd_data);
  assign parent    = (pos_r - ADDR_W'(1)) >> 1;
  assign lchild    = {1'b0, pos_r, 1'b1};
  assign rchild    = lchild + PTR_W'(1);
  assign cnt_ext   = PTR_W'(cnt_r);
  assign scan_prev = scan_r - CNT_W'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_top_r};
  assign out_tuser  = out_st_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    lval_nxt  = lval_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    scan_nxt  = scan_r;
    pend_nxt  = pend_r;
    st_nxt    = st_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = val_r;
    rd_en     = 1'b0;
    rd_addr   = parent;
    cand      = val_r;
    cand_idx  = pos_r;
    cand_move = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          val_nxt = $signed(in_tdata[DATA_W-1:0]);
          st_nxt  = ST_OK;
          case (in_tuser)
            CMD_PUSH: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                pos_nxt   = cnt_r[ADDR_W-1:0];
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            CMD_DELETE: begin
              scan_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            default: begin
              st_nxt    = (cnt_r == '0) ? ST_EMPTY : ST_OK;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Sift-up with a hole: smaller parents slide down until the new value fits.
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (val_r > rd_val) begin
          wr_data   = rd_data;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Reads are issued back to back; the data of the previous address is checked here.
      S_SCAN: begin
        if (pend_r && (rd_val == val_r)) begin
          pos_nxt   = scan_prev[ADDR_W-1:0];
          pend_nxt  = 1'b0;
          state_nxt = S_SH_RD;
        end else if (scan_r < cnt_r) begin
          rd_en    = 1'b1;
          rd_addr  = scan_r[ADDR_W-1:0];
          scan_nxt = scan_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end
      end

      S_SH_RD: begin
        if (pos_r == '0) begin
          state_nxt = S_LAST_RD;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        pos_nxt   = parent;
        state_nxt = S_SH_RD;
      end

      // The last entry is read only after the ancestor shift has been written back.
      S_LAST_RD: begin
        cnt_nxt   = cnt_r - CNT_W'(1);
        rd_en     = 1'b1;
        rd_addr   = cnt_nxt[ADDR_W-1:0];
        state_nxt = S_LAST_WR;
      end

      S_LAST_WR: begin
        val_nxt   = rd_val;
        pos_nxt   = '0;
        state_nxt = (cnt_r == '0) ? S_DONE : S_SD_L;
      end

      S_SD_L: begin
        if (lchild >= cnt_ext) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lchild[ADDR_W-1:0];
          state_nxt = S_SD_R;
        end
      end

      S_SD_R: begin
        lval_nxt = rd_val;
        if (rchild < cnt_ext) begin
          rd_en     = 1'b1;
          rd_addr   = rchild[ADDR_W-1:0];
          state_nxt = S_SD_C;
        end else begin
          wr_en = 1'b1;
          if (rd_val > val_r) begin
            wr_data   = rd_data;
            pos_nxt   = lchild[ADDR_W-1:0];
            state_nxt = S_SD_L;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // On a tie the left child wins, and a child equal to the hole value stays put.
      S_SD_C: begin
        if (lval_r > val_r) begin
          cand      = lval_r;
          cand_idx  = lchild[ADDR_W-1:0];
          cand_move = 1'b1;
        end
        if (rd_val > cand) begin
          cand      = rd_val;
          cand_idx  = rchild[ADDR_W-1:0];
          cand_move = 1'b1;
        end
        wr_en = 1'b1;
        if (cand_move) begin
          wr_data   = cand;
          pos_nxt   = cand_idx;
          state_nxt = S_SD_L;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    lval_r <= lval_nxt;
    pos_r  <= pos_nxt;
    scan_r <= scan_nxt;
    st_r   <= st_nxt;
    // The root is mirrored here so the top value needs no extra RAM read.
    if (wr_en && (wr_addr == '0)) begin
      root_r <= $signed(wr_data);
    end
    if (out_load) begin
      out_st_r  <= st_r;
      out_top_r <= (cnt_r == '0) ? '0 : root_r;
      out_cnt_r <= cnt_r;
    end
  end

endmodule

### dv/testbench.sv
// Self-checking testbench for the max heap priority queue: directed and random command words.
module testbench;
  import mhpq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int WORD_TARGET   = 1000;
  localparam int QUIET_TAIL    = 100;
  localparam int SETTLE_CYCLES = 120;

  typedef logic signed [DATA_W-1:0] value_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    value_t           top;
    logic [CNT_W-1:0] count;
  } heap_answer_t;

  // Keeps its own copy of the heap and the answers still owed by the block.
  class heap_scoreboard;
    value_t       slots[CAPACITY];
    int           fill;
    heap_answer_t answers_q[$];
    int           mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function value_t pick_stored();
      return slots[$urandom_range(0, fill - 1)];
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, value_t v);
      heap_answer_t a;
      int i, p, l, r, best;
      value_t t;
      a.status = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (fill >= CAPACITY) begin
            a.status = ST_FULL;
          end else begin
            i = fill;
            slots[i] = v;
            fill++;
            while (i > 0 && slots[i] > slots[(i - 1) / 2]) begin
              p = (i - 1) / 2;
              t = slots[i];
              slots[i] = slots[p];
              slots[p] = t;
              i = p;
            end
          end
        end
        CMD_DELETE: begin
          i = 0;
          while (i < fill && slots[i] != v) i++;
          if (i >= fill) begin
            a.status = ST_NOT_FOUND;
          end else begin
            // The hit slot climbs to the root while its ancestors move down a level.
            while (i > 0) begin
              p = (i - 1) / 2;
              slots[i] = slots[p];
              i = p;
            end
            fill--;
            slots[0] = slots[fill];
            i = 0;
            forever begin
              l = 2 * i + 1;
              r = l + 1;
              best = i;
              if (l < fill && slots[l] > slots[best]) best = l;
              if (r < fill && slots[r] > slots[best]) best = r;
              if (best == i) break;
              t = slots[i];
              slots[i] = slots[best];
              slots[best] = t;
              i = best;
            end
          end
        end
        default: begin
          if (fill == 0) a.status = ST_EMPTY;
        end
      endcase
      a.top = (fill == 0) ? '0 : slots[0];
      a.count = CNT_W'(fill);
      answers_q.insert(answers_q.size(), a);
    endfunction

    task check_result(logic [ST_W-1:0] st, value_t top, logic [CNT_W-1:0] cnt);
      heap_answer_t a;
      if (answers_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: status %0d top %0d count %0d",
                                  st, top, cnt));
        return;
      end
      a = answers_q.pop_front();
      if (st !== a.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, a.status));
      if (top !== a.top)
        report_mismatch($sformatf("top %0d, expected %0d", top, a.top));
      if (cnt !== a.count)
        report_mismatch($sformatf("count %0d, expected %0d", cnt, a.count));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // value[31:0]
  logic [CMD_W-1:0]      in_tuser;   // cmd[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // top_value[31:0], count[38:32], pad
  logic [ST_W-1:0]       out_tuser;  // status[1:0]

  heap_scoreboard sb = new();
  int  words_sent = 0;
  int  cycle_count = 0;
  bit  calm_stretch = 1'b0;

  max_heap_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[DATA_W-1:0], out_tdata[DATA_W+CNT_W-1:DATA_W]);
  end

  function automatic bit idling_allowed();
    return !calm_stretch && words_sent < WORD_TARGET - QUIET_TAIL;
  endfunction

  // Result side: ready drops for short random bursts.
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (idling_allowed() && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, value_t v);
    if (idling_allowed() && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, v);
    words_sent++;
  endtask

  // Always waits on the clock before the first check, so the next driver starts in a later time step.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.answers_q.size() != 0);
  endtask

  function automatic value_t any_value();
    case ($urandom_range(0, 5))
      0, 1: return value_t'($urandom_range(0, 8)) - 4;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a value that is stored, so deletes get past the scan.
  function automatic value_t delete_target();
    if (sb.fill > 0 && $urandom_range(0, 4) != 0) return sb.pick_stored();
    return any_value();
  endfunction

  function automatic logic [CMD_W-1:0] query_code();
    return ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_QUERY;
  endfunction

  initial begin
    int k;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_QUERY;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty heap, extremes, duplicates and deletes down to empty again.
    calm_stretch = 1'b1;
    send_word(CMD_QUERY, 0);
    send_word(CMD_DELETE, 5);
    send_word(CMD_SPARE, -1);
    send_word(CMD_PUSH, 32'sh7FFF_FFFF);
    send_word(CMD_PUSH, 32'sh8000_0000);
    send_word(CMD_PUSH, 0);
    send_word(CMD_PUSH, -1);
    send_word(CMD_PUSH, 7);
    send_word(CMD_PUSH, 7);
    send_word(CMD_PUSH, 1);
    send_word(CMD_QUERY, 32'sh5555_5555);
    send_word(CMD_SPARE, 0);
    send_word(CMD_DELETE, 7);
    send_word(CMD_DELETE, 100);
    send_word(CMD_DELETE, 32'sh7FFF_FFFF);
    send_word(CMD_DELETE, 32'sh8000_0000);
    send_word(CMD_DELETE, 7);
    send_word(CMD_DELETE, 0);
    send_word(CMD_DELETE, -1);
    send_word(CMD_DELETE, 1);
    send_word(CMD_QUERY, 0);
    wait_drained();

    while (words_sent < WORD_TARGET) begin
      calm_stretch = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: begin
          // Grow to capacity, then pushes that must be refused.
          while (sb.fill < CAPACITY) begin
            k = $urandom_range(0, 19);
            if (k < 17) send_word(CMD_PUSH, any_value());
            else if (k < 19) send_word(CMD_DELETE, delete_target());
            else send_word(query_code(), any_value());
          end
          repeat ($urandom_range(1, 4)) send_word(CMD_PUSH, any_value());
          send_word(query_code(), any_value());
        end
        1: begin
          while (sb.fill > 0) begin
            k = $urandom_range(0, 19);
            if (k < 18) send_word(CMD_DELETE, delete_target());
            else if (k < 19) send_word(CMD_PUSH, any_value());
            else send_word(query_code(), any_value());
          end
          send_word(CMD_DELETE, any_value());
          send_word(query_code(), any_value());
        end
        default: begin
          repeat ($urandom_range(20, 60)) begin
            k = $urandom_range(0, 3);
            if (k == 0) send_word(CMD_PUSH, any_value());
            else if (k == 1) send_word(CMD_DELETE, delete_target());
            else send_word(query_code(), any_value());
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.answers_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
